@@ rtl/core/nps_pkg.sv @@
// Shared types and constants for the nearest point search block.
package nps_pkg;

  localparam int unsigned CoordW = 24;
  localparam int unsigned IdxW   = 10;
  localparam int unsigned DistW  = 50;
  localparam int unsigned SqW    = 2 * CoordW;
  localparam int unsigned SumW   = SqW + 1;

  localparam logic ModeLoad  = 1'b0;
  localparam logic ModeQuery = 1'b1;

  typedef struct packed {
    logic                     mode;
    logic [IdxW-1:0]          entry_index;
    logic                     entry_valid;
    logic signed [CoordW-1:0] pos_x;
    logic signed [CoordW-1:0] pos_y;
  } in_item_t;

  typedef struct packed {
    logic             found;
    logic [IdxW-1:0]  nearest_index;
    logic [DistW-1:0] nearest_dist2;
  } out_item_t;

  // Table word: valid flag and stored point
  typedef struct packed {
    logic                     valid;
    logic signed [CoordW-1:0] x;
    logic signed [CoordW-1:0] y;
  } entry_t;

endpackage

@@ rtl/core/nps_dist_unit.sv @@
// Two-stage pipelined unit: absolute coordinate differences, then their squares.
module nps_dist_unit #(
  parameter int unsigned AW = 10
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             valid_i,
  input  logic [AW-1:0]                    idx_i,
  input  logic signed [nps_pkg::CoordW-1:0] ent_x_i,
  input  logic signed [nps_pkg::CoordW-1:0] ent_y_i,
  input  logic signed [nps_pkg::CoordW-1:0] qry_x_i,
  input  logic signed [nps_pkg::CoordW-1:0] qry_y_i,
  output logic                             valid_o,
  output logic [AW-1:0]                    idx_o,
  output logic [nps_pkg::SqW-1:0]          sq_x_o,
  output logic [nps_pkg::SqW-1:0]          sq_y_o,
  output logic                             busy_o
);
  import nps_pkg::*;

  logic signed [CoordW:0] dx, dy;
  logic [CoordW-1:0]      abs_x_d, abs_y_d;
  logic [CoordW-1:0]      abs_x_q, abs_y_q;
  logic                   v_a_q, v_b_q;
  logic [AW-1:0]          idx_a_q, idx_b_q;
  logic [SqW-1:0]         sq_x_q, sq_y_q;

  always_comb begin
    dx = {ent_x_i[CoordW-1], ent_x_i} - {qry_x_i[CoordW-1], qry_x_i};
    dy = {ent_y_i[CoordW-1], ent_y_i} - {qry_y_i[CoordW-1], qry_y_i};
    // magnitude of a difference never exceeds 2^24-1
    abs_x_d = dx[CoordW] ? CoordW'(-dx) : dx[CoordW-1:0];
    abs_y_d = dy[CoordW] ? CoordW'(-dy) : dy[CoordW-1:0];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_a_q <= 1'b0;
      v_b_q <= 1'b0;
    end else begin
      v_a_q <= valid_i;
      v_b_q <= v_a_q;
    end
  end

  always_ff @(posedge clk_i) begin
    abs_x_q <= abs_x_d;
    abs_y_q <= abs_y_d;
    idx_a_q <= idx_i;
    sq_x_q  <= SqW'(abs_x_q) * SqW'(abs_x_q);
    sq_y_q  <= SqW'(abs_y_q) * SqW'(abs_y_q);
    idx_b_q <= idx_a_q;
  end

  assign valid_o = v_b_q;
  assign idx_o   = idx_b_q;
  assign sq_x_o  = sq_x_q;
  assign sq_y_o  = sq_y_q;
  assign busy_o  = v_a_q | v_b_q;

endmodule

@@ rtl/core/nearest_point_search_core.sv @@
// Load item: written to the table at the edge that accepts it. Query item: one table
// read per cycle through the table memory's single read port into the distance pipe.
// Input is stalled for the whole query until its result is registered; the next item is taken right after.
// After reset a clearing pass zeroes every valid flag; input stays stalled until it ends.
// Top level: 2-D point table with brute-force nearest entry query.
module nearest_point_search_core #(
  parameter int unsigned TABLE_ENTRIES = 1024
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_stall_o,
  input  nps_pkg::in_item_t  in_item_i,
  output logic              out_valid_o,
  input  logic              out_stall_i,
  output nps_pkg::out_item_t out_item_o
);
  import nps_pkg::*;

  localparam int unsigned AW = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
  localparam logic [AW-1:0] LastIdx = AW'(TABLE_ENTRIES - 1);

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_SCAN,
    ST_DRAIN,
    ST_FINISH
  } state_e;

  state_e                   state_q;
  logic [AW-1:0]            cnt_q;
  logic signed [CoordW-1:0] qx_q, qy_q;
  logic                     found_q;
  logic [AW-1:0]            best_idx_q;
  logic [SumW-1:0]          best_d_q;
  logic                     out_valid_q;
  out_item_t                out_item_q;
  logic                     rd_v_q;
  logic [AW-1:0]            rd_idx_q;

  entry_t                   mem [TABLE_ENTRIES];
  entry_t                   rd_q;
  logic                     wr_en;
  logic [AW-1:0]            wr_addr;
  entry_t                   wr_data;

  logic                     in_acc;
  logic                     load_in_range;
  logic                     u_valid;
  logic [AW-1:0]            u_idx;
  logic [SqW-1:0]           u_sq_x, u_sq_y;
  logic                     u_busy;
  logic [SumW-1:0]          dist_sum;
  logic                     better;
  logic                     out_free;

  assign in_stall_o    = (state_q != ST_IDLE);
  assign in_acc        = in_valid_i & ~in_stall_o;
  assign load_in_range = (32'(in_item_i.entry_index) < 32'(TABLE_ENTRIES));

  always_comb begin
    wr_en   = 1'b0;
    wr_addr = AW'(in_item_i.entry_index);
    wr_data = '{valid: in_item_i.entry_valid, x: in_item_i.pos_x, y: in_item_i.pos_y};
    if (state_q == ST_CLEAR) begin
      wr_en   = 1'b1;
      wr_addr = cnt_q;
      wr_data = '0;
    end else if (in_acc && in_item_i.mode == ModeLoad && load_in_range) begin
      wr_en = 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk_i) begin
    rd_q     <= mem[cnt_q];
    rd_idx_q <= cnt_q;
  end

  nps_dist_unit #(
    .AW (AW)
  ) u_dist (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (rd_v_q & rd_q.valid),
    .idx_i   (rd_idx_q),
    .ent_x_i (rd_q.x),
    .ent_y_i (rd_q.y),
    .qry_x_i (qx_q),
    .qry_y_i (qy_q),
    .valid_o (u_valid),
    .idx_o   (u_idx),
    .sq_x_o  (u_sq_x),
    .sq_y_o  (u_sq_y),
    .busy_o  (u_busy)
  );

  assign dist_sum = {1'b0, u_sq_x} + {1'b0, u_sq_y};
  assign better   = u_valid & (~found_q | (dist_sum < best_d_q));
  assign out_free = ~out_valid_q | ~out_stall_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_CLEAR;
      cnt_q       <= '0;
      qx_q        <= '0;
      qy_q        <= '0;
      found_q     <= 1'b0;
      best_idx_q  <= '0;
      best_d_q    <= '0;
      rd_v_q      <= 1'b0;
      out_valid_q <= 1'b0;
      out_item_q  <= '0;
    end else begin
      rd_v_q <= (state_q == ST_SCAN);
      if (out_valid_q && !out_stall_i) begin
        out_valid_q <= 1'b0;
      end
      if (better) begin
        found_q    <= 1'b1;
        best_idx_q <= u_idx;
        best_d_q   <= dist_sum;
      end
      unique case (state_q)
        ST_CLEAR: begin
          cnt_q <= cnt_q + 1'b1;
          if (cnt_q == LastIdx) begin
            cnt_q   <= '0;
            state_q <= ST_IDLE;
          end
        end
        ST_IDLE: begin
          if (in_acc && in_item_i.mode == ModeQuery) begin
            qx_q       <= in_item_i.pos_x;
            qy_q       <= in_item_i.pos_y;
            found_q    <= 1'b0;
            best_idx_q <= '0;
            best_d_q   <= '0;
            cnt_q      <= '0;
            state_q    <= ST_SCAN;
          end
        end
        ST_SCAN: begin
          cnt_q <= cnt_q + 1'b1;
          if (cnt_q == LastIdx) begin
            cnt_q   <= '0;
            state_q <= ST_DRAIN;
          end
        end
        ST_DRAIN: begin
          // last compare has landed once the read stage and the pipe are empty
          if (!rd_v_q && !u_busy) begin
            state_q <= ST_FINISH;
          end
        end
        ST_FINISH: begin
          if (out_free) begin
            out_valid_q              <= 1'b1;
            out_item_q.found         <= found_q;
            out_item_q.nearest_index <= IdxW'(best_idx_q);
            out_item_q.nearest_dist2 <= DistW'(best_d_q);
            state_q                  <= ST_IDLE;
          end
        end
        default: state_q <= ST_IDLE;
      endcase
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_item_q;

endmodule

@@ test/nearest_point_search_core_tb.sv @@
// Testbench for the nearest point search core: table loads and nearest-entry queries.
`timescale 1ns / 100ps

module nearest_point_search_core_tb;
  import nps_pkg::*;

  localparam int unsigned TBL_ENTRIES    = 1024;
  localparam int unsigned CLK_PERIOD     = 12;
  localparam int unsigned HOLD_CYCLES    = 4000;
  localparam int unsigned DRAIN_CYCLES   = TBL_ENTRIES + 64;
  // ~600 items, all queries with a full table scan each plus stalls, taken several times over
  localparam int unsigned TIMEOUT_CYCLES = 3_000_000;
  localparam int unsigned HOT_N          = 24;

  localparam logic signed [CoordW-1:0] COORD_MIN = {1'b1, {(CoordW-1){1'b0}}};
  localparam logic signed [CoordW-1:0] COORD_MAX = {1'b0, {(CoordW-1){1'b1}}};

  logic      clk;
  logic      rst_n;
  logic      in_valid;
  logic      in_stall;
  in_item_t  in_item;
  logic      out_valid;
  logic      out_stall;
  out_item_t out_item;

  // Shadow copy of the point table
  logic signed [CoordW-1:0] pt_x [TBL_ENTRIES];
  logic signed [CoordW-1:0] pt_y [TBL_ENTRIES];
  bit                       pt_valid [TBL_ENTRIES];
  out_item_t                nearest_q [$];

  logic [IdxW-1:0] hot_idx [HOT_N];
  int unsigned     errors, n_loads, n_clears, n_queries, n_checked;
  int unsigned     burst_left;
  bit              hold_req;
  int unsigned     hold_left, seg_left, stall_mode, stall_cyc;
  out_item_t       want;

  nearest_point_search_core #(
    .TABLE_ENTRIES(TBL_ENTRIES)
  ) dut (
    .clk_i      (clk),
    .rst_ni     (rst_n),
    .in_valid_i (in_valid),
    .in_stall_o (in_stall),
    .in_item_i  (in_item),
    .out_valid_o(out_valid),
    .out_stall_i(out_stall),
    .out_item_o (out_item)
  );

  initial begin
    clk = 1'b0;
    forever #(CLK_PERIOD / 2) clk = ~clk;
  end

  function automatic logic [DistW-1:0] sq_dist(input logic signed [CoordW-1:0] ax, ay, bx, by);
    longint dx, dy;
    dx = longint'(ax) - longint'(bx);
    dy = longint'(ay) - longint'(by);
    return DistW'(dx * dx + dy * dy);
  endfunction

  // Strict compare in ascending index order: lowest index wins a tie
  function automatic out_item_t nearest_entry(input logic signed [CoordW-1:0] qx, qy);
    out_item_t        res;
    logic [DistW-1:0] d;
    res = '0;
    for (int i = 0; i < TBL_ENTRIES; i++) begin
      if (pt_valid[i]) begin
        d = sq_dist(qx, qy, pt_x[i], pt_y[i]);
        if (!res.found || d < res.nearest_dist2) begin
          res.found         = 1'b1;
          res.nearest_index = IdxW'(i);
          res.nearest_dist2 = d;
        end
      end
    end
    return res;
  endfunction

  // Called at the accepting edge; items are handled in order
  function automatic void record_item(input in_item_t it);
    if (it.mode == ModeQuery) begin
      nearest_q.push_back(nearest_entry(it.pos_x, it.pos_y));
      n_queries++;
    end else if (it.entry_index < TBL_ENTRIES) begin
      if (it.entry_valid) begin
        pt_x[it.entry_index]     = it.pos_x;
        pt_y[it.entry_index]     = it.pos_y;
        pt_valid[it.entry_index] = 1'b1;
        n_loads++;
      end else begin
        pt_valid[it.entry_index] = 1'b0;
        n_clears++;
      end
    end
  endfunction

  function automatic in_item_t mk_item(input logic mode, input logic [IdxW-1:0] idx,
                                       input logic vld, input logic signed [CoordW-1:0] x, y);
    in_item_t it;
    it.mode        = mode;
    it.entry_index = idx;
    it.entry_valid = vld;
    it.pos_x       = x;
    it.pos_y       = y;
    return it;
  endfunction

  function automatic logic signed [CoordW-1:0] pick_coord(input bit clustered);
    logic signed [CoordW-1:0] c;
    int unsigned              r;
    r = $urandom_range(0, 9);
    if (r == 0) c = COORD_MIN;
    else if (r == 1) c = COORD_MAX;
    else if (r < (clustered ? 4 : 8)) c = CoordW'($urandom);
    else c = CoordW'(int'($urandom_range(0, 128)) - 64);
    return c;
  endfunction

  // Mostly a small pool so clears and overwrites hit live entries
  function automatic logic [IdxW-1:0] pick_index();
    if ($urandom_range(0, 3) == 0) return IdxW'($urandom);
    return hot_idx[$urandom_range(0, HOT_N - 1)];
  endfunction

  // Entered and left at a falling edge
  task automatic send_item(input in_item_t it);
    int unsigned gap;
    in_valid <= 1'b1;
    in_item  <= it;
    do @(posedge clk); while (in_stall);
    record_item(it);
    @(negedge clk);
    if (burst_left > 0) begin
      burst_left--;
    end else begin
      gap = $urandom_range(0, 5);
      if (gap > 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(negedge clk);
      end
      burst_left = ($urandom_range(0, 3) == 0) ? 40 : $urandom_range(0, 12);
    end
  endtask

  task automatic test_empty_table();
    send_item(mk_item(ModeLoad, 10'd7, 1'b0, COORD_MAX, COORD_MIN));
    send_item(mk_item(ModeQuery, IdxW'($urandom), 1'b1, COORD_MAX, COORD_MAX));
    send_item(mk_item(ModeQuery, IdxW'($urandom), 1'b0, COORD_MIN, COORD_MIN));
  endtask

  task automatic test_extremes();
    send_item(mk_item(ModeLoad, 10'd0, 1'b1, COORD_MIN, COORD_MIN));
    send_item(mk_item(ModeLoad, 10'd1023, 1'b1, COORD_MAX, COORD_MAX));
    send_item(mk_item(ModeQuery, IdxW'($urandom), 1'b1, COORD_MAX, COORD_MAX));
    send_item(mk_item(ModeQuery, IdxW'($urandom), 1'b1, COORD_MIN, COORD_MAX));
    send_item(mk_item(ModeLoad, 10'd1023, 1'b0, '0, '0));
    // only the opposite corner is left: largest possible distance
    send_item(mk_item(ModeQuery, IdxW'($urandom), 1'b1, COORD_MAX, COORD_MAX));
  endtask

  task automatic test_tie_break();
    send_item(mk_item(ModeLoad, 10'd20, 1'b1, 24'sd100, 24'sd0));
    send_item(mk_item(ModeLoad, 10'd10, 1'b1, -24'sd100, 24'sd0));
    send_item(mk_item(ModeQuery, IdxW'($urandom), 1'b0, 24'sd0, 24'sd0));
    send_item(mk_item(ModeLoad, 10'd5, 1'b1, 24'sd0, -24'sd100));
    send_item(mk_item(ModeLoad, 10'd3, 1'b1, 24'sd0, 24'sd100));
    send_item(mk_item(ModeQuery, IdxW'($urandom), 1'b1, 24'sd0, 24'sd0));
    send_item(mk_item(ModeQuery, IdxW'($urandom), 1'b1, 24'sd1, 24'sd0));
  endtask

  task automatic test_clear_entries();
    send_item(mk_item(ModeLoad, 10'd3, 1'b0, COORD_MIN, COORD_MAX));
    send_item(mk_item(ModeLoad, 10'd0, 1'b0, '0, '0));
    send_item(mk_item(ModeLoad, 10'd3, 1'b1, 24'sd5, 24'sd5));
    send_item(mk_item(ModeQuery, IdxW'($urandom), 1'b1, 24'sd0, 24'sd0));
    send_item(mk_item(ModeLoad, 10'd3, 1'b0, '0, '0));
    send_item(mk_item(ModeLoad, 10'd5, 1'b0, '0, '0));
    send_item(mk_item(ModeLoad, 10'd10, 1'b0, '0, '0));
    send_item(mk_item(ModeLoad, 10'd20, 1'b0, '0, '0));
    send_item(mk_item(ModeQuery, IdxW'($urandom), 1'b1, 24'sd5, 24'sd5));
  endtask

  task automatic test_random_traffic(input int unsigned n_items);
    in_item_t    it;
    int unsigned sel;
    bit          clus;
    for (int unsigned k = 0; k < n_items; k++) begin
      sel  = $urandom_range(0, 99);
      clus = ($urandom_range(0, 4) < 3);
      it   = mk_item(ModeLoad, pick_index(), 1'b1, pick_coord(clus), pick_coord(clus));
      if (sel < 38) begin
        it.mode        = ModeQuery;
        it.entry_index = IdxW'($urandom);
        it.entry_valid = 1'($urandom_range(0, 1));
      end else if (sel < 55) begin
        it.entry_valid = 1'b0;
      end
      send_item(it);
    end
  endtask

  // Receiver holds off while queries keep coming, so the core backs up
  task automatic test_output_hold();
    hold_req = 1'b1;
    for (int unsigned k = 0; k < 10; k++)
      send_item(mk_item((k % 3 == 1) ? ModeQuery : ModeLoad, pick_index(), 1'b1,
                        pick_coord(1'b1), pick_coord(1'b1)));
  endtask

  // Receiver stall: random segments of different patterns, plus the long hold-off
  initial begin
    out_stall  = 1'b0;
    hold_left  = 0;
    seg_left   = 0;
    stall_mode = 0;
    stall_cyc  = 0;
    forever begin
      @(negedge clk);
      if (hold_req) begin
        hold_req  = 1'b0;
        hold_left = HOLD_CYCLES;
      end
      if (seg_left == 0) begin
        stall_mode = $urandom_range(0, 3);
        seg_left   = $urandom_range(50, 400);
      end else begin
        seg_left--;
      end
      stall_cyc++;
      if (hold_left > 0) begin
        hold_left--;
        out_stall <= 1'b1;
      end else begin
        case (stall_mode)
          0: out_stall <= 1'b0;
          1: out_stall <= ($urandom_range(0, 2) == 0);
          2: out_stall <= ((stall_cyc % 5) < 2);
          default: out_stall <= ($urandom_range(0, 3) != 0);
        endcase
      end
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) begin
      if (nearest_q.size() == 0) begin
        $display("%0t: result with none expected, actual found %0d index %0d dist2 %0d",
                 $time, out_item.found, out_item.nearest_index, out_item.nearest_dist2);
        errors++;
      end else begin
        want = nearest_q.pop_front();
        n_checked++;
        if (out_item.found !== want.found) begin
          $display("%0t: found mismatch, expected %0d, actual %0d",
                   $time, want.found, out_item.found);
          errors++;
        end
        if (out_item.nearest_index !== want.nearest_index) begin
          $display("%0t: nearest_index mismatch, expected %0d, actual %0d",
                   $time, want.nearest_index, out_item.nearest_index);
          errors++;
        end
        if (out_item.nearest_dist2 !== want.nearest_dist2) begin
          $display("%0t: nearest_dist2 mismatch, expected %0d, actual %0d",
                   $time, want.nearest_dist2, out_item.nearest_dist2);
          errors++;
        end
      end
    end
  end

  initial begin
    #(TIMEOUT_CYCLES * CLK_PERIOD);
    $display("%0t: timeout with %0d results outstanding", $time, nearest_q.size());
    $display("== FAIL ==");
    $finish;
  end

  initial begin
    rst_n      = 1'b0;
    in_valid   = 1'b0;
    in_item    = '0;
    hold_req   = 1'b0;
    burst_left = 0;
    errors     = 0;
    n_loads    = 0;
    n_clears   = 0;
    n_queries  = 0;
    n_checked  = 0;
    hot_idx[0] = '0;
    hot_idx[1] = '1;
    for (int i = 2; i < HOT_N; i++) hot_idx[i] = IdxW'($urandom);
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    test_empty_table();
    test_extremes();
    test_tie_break();
    test_clear_entries();
    test_random_traffic(280);
    test_output_hold();
    test_random_traffic(280);
    in_valid <= 1'b0;

    while (nearest_q.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("Covered %0d point loads, %0d entry clears and %0d nearest queries (%0d checked),",
             n_loads, n_clears, n_queries, n_checked);
    $display("with sender gaps, mixed output stall patterns and one long output hold-off.");
    if (errors == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
